>>> rtl/core/uset_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uset_pkg: shared constants and codes for the unordered set
// Table size, value width and the command and status encodings.
// ----------------------------------------------------------------------------
package uset_pkg;

    localparam int CAPACITY    = 64;
    localparam int VALUE_WIDTH = 32;
    localparam int ADDR_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int COUNT_W     = 7;
    localparam int CMD_W       = 2;
    localparam int STATUS_W    = 2;
    localparam int OUT_W       = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_ENUM   = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_EMPTY     = 2'd3
    } status_t;

endpackage
`default_nettype wire

>>> rtl/core/unordered_set_swap_remove.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// unordered_set_swap_remove: table-backed unordered set
// Add appends, remove swaps the last entry into the matching slot, enumerate
// streams all stored values. One table read port is shared by every step.
// ----------------------------------------------------------------------------
//
// channel   | signals                                 | handshake
// ----------+-----------------------------------------+-------------------------
// command   | command, item_value                     | start high, busy low
// result    | status, out_value, item_count, last     | done strobe, one cycle
//
// Sequencing: add and the unused code finish in the accept cycle; the result
// strobes the next cycle and busy stays low. Remove scans one entry per cycle
// through the single table read port up to a miss, or up to a hit followed by a
// fetch of the last entry and a move of it into the hit slot. Enumerate emits
// one word per cycle once the registered read of the first entry is back.
// Reset clears the count, the sequencer and the done, status and last flags;
// the table is not cleared, since no entry at or above the count is ever used.
// The receiver cannot stall; each result word is valid for exactly one cycle.
// ----------------------------------------------------------------------------

module unordered_set_swap_remove
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    output      logic                            busy,
    input  wire logic [uset_pkg::CMD_W-1:0]      command,
    input  wire logic [31:0]                     item_value,
    output      logic                            done,
    output      logic [uset_pkg::STATUS_W-1:0]   status,
    output      logic [uset_pkg::OUT_W-1:0]      out_value,
    output      logic [uset_pkg::COUNT_W-1:0]    item_count,
    output      logic                            last
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,     // remove: stream reads, compare the previous read
        S_FETCH,    // remove: read the last entry after a hit
        S_MOVE,     // remove: write last entry into the hit slot
        S_ENUM      // enumerate: stream reads, emit the previous read
    } state_t;

    localparam int AW = uset_pkg::ADDR_W;
    localparam int CW = uset_pkg::COUNT_W;
    localparam int VW = uset_pkg::VALUE_WIDTH;

    // table storage, one write and one registered read per cycle
    logic [VW-1:0] mem [uset_pkg::CAPACITY];
    logic [VW-1:0] rd_data;

    state_t             state_reg,   state_next;
    logic [CW-1:0]      cnt_reg,     cnt_next;
    logic [AW-1:0]      idx_reg,     idx_next;      // next read address
    logic [AW-1:0]      pidx_reg,    pidx_next;     // address of rd_data
    logic               pend_reg,    pend_next;     // rd_data holds a valid read
    logic [AW-1:0]      hit_reg,     hit_next;
    logic [VW-1:0]      val_reg,     val_next;
    logic               done_reg,    done_next;
    uset_pkg::status_t  status_reg,  status_next;
    logic [uset_pkg::OUT_W-1:0] outv_reg, outv_next;
    logic               last_reg,    last_next;

    logic               we;
    logic [AW-1:0]      wa;
    logic [VW-1:0]      wd;
    logic [AW-1:0]      ra;

    logic               accept;
    logic               full;
    logic [CW-1:0]      cnt_m1;
    logic               pend_is_last;
    logic [VW-1:0]      in_val;

    assign accept       = start && (state_reg == S_IDLE);
    assign full         = (cnt_reg >= CW'(uset_pkg::CAPACITY));
    assign cnt_m1       = cnt_reg - CW'(1);
    assign pend_is_last = ({{(CW-AW){1'b0}}, pidx_reg} == cnt_m1);
    assign in_val       = VW'(item_value);

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        rd_data <= mem[ra];
    end

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        idx_next    = idx_reg;
        pidx_next   = pidx_reg;
        pend_next   = pend_reg;
        hit_next    = hit_reg;
        val_next    = val_reg;
        done_next   = 1'b0;
        status_next = uset_pkg::ST_OK;
        outv_next   = '0;
        last_next   = 1'b1;
        we          = 1'b0;
        wa          = cnt_reg[AW-1:0];
        wd          = in_val;
        ra          = idx_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    val_next  = in_val;
                    idx_next  = '0;
                    pend_next = 1'b0;
                    unique case (uset_pkg::cmd_t'(command))
                        uset_pkg::CMD_ADD:
                        begin
                            done_next = 1'b1;
                            if (full)
                            begin
                                status_next = uset_pkg::ST_FULL;
                            end
                            else
                            begin
                                we       = 1'b1;
                                cnt_next = cnt_reg + CW'(1);
                            end
                        end
                        uset_pkg::CMD_REMOVE:
                        begin
                            if (cnt_reg == '0)
                            begin
                                done_next   = 1'b1;
                                status_next = uset_pkg::ST_NOT_FOUND;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        uset_pkg::CMD_ENUM:
                        begin
                            if (cnt_reg == '0)
                            begin
                                done_next   = 1'b1;
                                status_next = uset_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                state_next = S_ENUM;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // keep reading ahead; reads past the count are discarded
                pend_next = 1'b1;
                pidx_next = idx_reg;
                idx_next  = idx_reg + AW'(1);
                if (pend_reg && (rd_data == val_reg))
                begin
                    hit_next   = pidx_reg;
                    cnt_next   = cnt_m1;
                    state_next = S_FETCH;
                end
                else if (pend_reg && pend_is_last)
                begin
                    done_next   = 1'b1;
                    status_next = uset_pkg::ST_NOT_FOUND;
                    state_next  = S_IDLE;
                end
            end

            S_FETCH:
            begin
                ra         = cnt_reg[AW-1:0];
                state_next = S_MOVE;
            end

            S_MOVE:
            begin
                we         = 1'b1;
                wa         = hit_reg;
                wd         = rd_data;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            S_ENUM:
            begin
                pend_next = 1'b1;
                pidx_next = idx_reg;
                idx_next  = idx_reg + AW'(1);
                if (pend_reg)
                begin
                    done_next = 1'b1;
                    outv_next = uset_pkg::OUT_W'(rd_data);
                    last_next = pend_is_last;
                    if (pend_is_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            pend_reg   <= 1'b0;
            done_reg   <= 1'b0;
            status_reg <= uset_pkg::ST_OK;
            last_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            pend_reg   <= pend_next;
            done_reg   <= done_next;
            status_reg <= status_next;
            last_reg   <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        pidx_reg <= pidx_next;
        hit_reg  <= hit_next;
        val_reg  <= val_next;
        outv_reg <= outv_next;
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign status     = status_reg;
    assign out_value  = outv_reg;
    assign item_count = cnt_reg;
    assign last       = last_reg;

`ifndef SYNTHESIS
    // count never exceeds the table size
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(uset_pkg::CAPACITY))
        else $error("count above capacity");

    // a full report only comes with a full table
    a_full_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg == uset_pkg::ST_FULL)
            |-> cnt_reg == CW'(uset_pkg::CAPACITY))
        else $error("full reported below capacity");

    // a word without last is only ever an enumerate word
    a_nonlast_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && !last_reg) |-> (status_reg == uset_pkg::ST_OK && busy))
        else $error("non-final word outside enumerate");

    // a successful remove lowers the count by one
    a_rm_dec: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && state_next == S_FETCH)
            |=> cnt_reg == $past(cnt_reg) - CW'(1))
        else $error("remove hit without count decrement");
`endif

endmodule
`default_nettype wire

>>> test/tb_unordered_set_swap_remove.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_unordered_set_swap_remove: self-checking bench for the unordered set
// Directed table first, then random add/remove/enumerate traffic. Every
// result word is checked field by field against a directed row or the set shadow.
// ----------------------------------------------------------------------------
module tb_unordered_set_swap_remove;

    import uset_pkg::*;

    // Longest correct silent stretch: the longest sender gap followed by a
    // full-table remove scan. Allow a wide margin.
    localparam int STALL_LIMIT  = 1000;
    // Extra cycles after the last expected word; catches stray strobes.
    localparam int DRAIN_CYCLES = 16;
    // Values are masked to the stored width before compare/store.
    localparam logic [31:0] VAL_MASK = (VALUE_WIDTH >= 32) ? 32'hFFFF_FFFF
                                       : ((32'd1 << VALUE_WIDTH) - 32'd1);

    // One result word as seen on the result ports.
    typedef struct packed {
        status_t              status;
        logic [OUT_W-1:0]     value;
        logic [COUNT_W-1:0]   cnt;
        logic                 last;
    } set_word_t;

    // Directed stimulus row. When 'typed' is set the row causes exactly one
    // word: the given status and count, out_value 0 and last 1.
    typedef struct packed {
        cmd_t                 op;
        logic [31:0]          operand;
        logic                 typed;
        status_t              status;
        logic [COUNT_W-1:0]   cnt;
    } plan_row_t;

    // Traffic shapes for the random part.
    typedef enum int {
        MODE_MIX,
        MODE_GROW,
        MODE_SHRINK
    } traffic_mode_t;

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    logic [CMD_W-1:0]       command;
    logic [31:0]            item_value;
    logic                   done;
    logic [STATUS_W-1:0]    status;
    logic [OUT_W-1:0]       out_value;
    logic [COUNT_W-1:0]     item_count;
    logic                   last;

    // Shadow of the set: table contents and fill count.
    logic [31:0]            shadow_vals [CAPACITY];
    int                     shadow_cnt;
    // Words still owed by the block, oldest first.
    set_word_t              pending_words [$];
    int                     error_count;
    int                     stall_cycles = 0;

    // Directed part: empty-set cases, unused code, extreme values, duplicate
    // add, miss, hit at the first and at the last slot, drain back to empty.
    plan_row_t dir_plan [0:21] = '{
        '{CMD_ENUM,   32'h0000_0000, 1'b1, ST_EMPTY,     7'd0},
        '{CMD_REMOVE, 32'h0000_0000, 1'b1, ST_NOT_FOUND, 7'd0},
        '{CMD_NOP,    32'hFFFF_FFFF, 1'b1, ST_OK,        7'd0},
        '{CMD_ADD,    32'h0000_0000, 1'b1, ST_OK,        7'd1},
        '{CMD_ADD,    32'hFFFF_FFFF, 1'b1, ST_OK,        7'd2},
        '{CMD_ADD,    32'h5555_5555, 1'b1, ST_OK,        7'd3},
        '{CMD_ADD,    32'hAAAA_AAAA, 1'b1, ST_OK,        7'd4},
        '{CMD_ADD,    32'h0000_0000, 1'b1, ST_OK,        7'd5},
        '{CMD_ENUM,   32'h0000_0000, 1'b0, ST_OK,        7'd0},
        '{CMD_REMOVE, 32'h0000_1234, 1'b1, ST_NOT_FOUND, 7'd5},
        '{CMD_REMOVE, 32'h0000_0000, 1'b1, ST_OK,        7'd4},
        '{CMD_ENUM,   32'h0000_0000, 1'b0, ST_OK,        7'd0},
        '{CMD_REMOVE, 32'hAAAA_AAAA, 1'b1, ST_OK,        7'd3},
        '{CMD_REMOVE, 32'h0000_0000, 1'b1, ST_OK,        7'd2},
        '{CMD_REMOVE, 32'h0000_0000, 1'b1, ST_NOT_FOUND, 7'd2},
        '{CMD_ENUM,   32'hFFFF_FFFF, 1'b0, ST_OK,        7'd0},
        '{CMD_NOP,    32'h0000_0000, 1'b1, ST_OK,        7'd2},
        '{CMD_REMOVE, 32'hFFFF_FFFF, 1'b1, ST_OK,        7'd1},
        '{CMD_REMOVE, 32'h5555_5555, 1'b1, ST_OK,        7'd0},
        '{CMD_ENUM,   32'h0000_0000, 1'b1, ST_EMPTY,     7'd0},
        '{CMD_ADD,    32'h8000_0001, 1'b1, ST_OK,        7'd1},
        '{CMD_ENUM,   32'h0000_0000, 1'b0, ST_OK,        7'd0}
    };

    unordered_set_swap_remove i_dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .command    (command),
        .item_value (item_value),
        .done       (done),
        .status     (status),
        .out_value  (out_value),
        .item_count (item_count),
        .last       (last)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Shadow of the set
    // ------------------------------------------------------------------------

    // Queue one expected word; the count is the one after the operation.
    function automatic void owe_word(status_t st, logic [31:0] v, logic last_flag);
        set_word_t w;
        w.status = st;
        w.value  = v;
        w.cnt    = COUNT_W'(shadow_cnt);
        w.last   = last_flag;
        pending_words.push_back(w);
    endfunction

    // Apply one accepted command to the shadow and queue its words.
    function automatic void apply_set_op(cmd_t op, logic [31:0] raw);
        logic [31:0] v;
        int          hit;
        v   = raw & VAL_MASK;
        hit = -1;
        case (op)
            CMD_ADD:
                if (shadow_cnt >= CAPACITY)
                    owe_word(ST_FULL, '0, 1'b1);       // table untouched
                else
                begin
                    shadow_vals[shadow_cnt] = v;       // no duplicate check
                    shadow_cnt++;
                    owe_word(ST_OK, '0, 1'b1);
                end
            CMD_REMOVE:
            begin
                // first match from entry 0 wins
                for (int i = 0; i < shadow_cnt; i++)
                    if (hit < 0 && shadow_vals[i] == v)
                        hit = i;
                if (hit < 0)
                    owe_word(ST_NOT_FOUND, '0, 1'b1);
                else
                begin
                    // last entry fills the hole
                    shadow_cnt--;
                    shadow_vals[hit] = shadow_vals[shadow_cnt];
                    owe_word(ST_OK, '0, 1'b1);
                end
            end
            CMD_ENUM:
                if (shadow_cnt == 0)
                    owe_word(ST_EMPTY, '0, 1'b1);
                else
                    for (int i = 0; i < shadow_cnt; i++)
                        owe_word(ST_OK, shadow_vals[i], i == shadow_cnt - 1);
            default:
                owe_word(ST_OK, '0, 1'b1);             // unused code: no-op
        endcase
    endfunction

    // Value for an add: fully random, a small pool (forces duplicates),
    // a copy of a stored value, or near all-ones.
    function automatic logic [31:0] pick_add_value();
        case ($urandom_range(0, 3))
            0:       return $urandom;
            1:       return $urandom_range(0, 7);
            2:       return (shadow_cnt > 0)
                            ? shadow_vals[$urandom_range(0, shadow_cnt - 1)]
                            : $urandom;
            default: return 32'hFFFF_FFFF - $urandom_range(0, 7);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------

    // Present one command word at the falling edge and hold it until the
    // rising edge where busy is low. busy is read as it stood before the edge.
    task automatic send_word(cmd_t op, logic [31:0] operand);
        @(negedge clk);
        start      <= 1'b1;
        command    <= op;
        item_value <= operand;
        do
            @(posedge clk);
        while (busy);
        apply_set_op(op, operand);
    endtask

    // Drop start; n sets the length of the pause.
    task automatic sender_pause(int n);
        @(negedge clk);
        start <= 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    // Stop sending and wait until every owed word has come back.
    task automatic wait_drained();
        @(negedge clk);
        start <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
    endtask

    // Random traffic. Most removes target a stored value so the scan hits at
    // every depth; the rest are misses and near misses. Unused codes are mixed in too.
    task automatic run_traffic(traffic_mode_t mode, int n_items, bit quiet);
        int          pause_pct;
        int          add_lim;
        int          hit_lim;
        int          miss_lim;
        int          enum_lim;
        int          r;
        cmd_t        op;
        logic [31:0] operand;
        // per-segment gap density; zero gives long back-to-back stretches
        pause_pct = quiet ? 0 : $urandom_range(0, 50);
        case (mode)
            MODE_GROW:   begin add_lim = 70; hit_lim = 80; miss_lim = 85; enum_lim = 95; end
            MODE_SHRINK: begin add_lim = 15; hit_lim = 70; miss_lim = 80; enum_lim = 95; end
            default:     begin add_lim = 35; hit_lim = 65; miss_lim = 75; enum_lim = 95; end
        endcase
        repeat (n_items)
        begin
            r = $urandom_range(0, 99);
            if (r < add_lim)
            begin
                op      = CMD_ADD;
                operand = pick_add_value();
            end
            else if (r < hit_lim)
            begin
                op      = CMD_REMOVE;
                operand = (shadow_cnt > 0)
                          ? shadow_vals[$urandom_range(0, shadow_cnt - 1)] : $urandom;
            end
            else if (r < miss_lim)
            begin
                op = CMD_REMOVE;
                // one flipped bit off a stored value, or plain random
                if (shadow_cnt > 0 && $urandom_range(0, 1))
                    operand = shadow_vals[$urandom_range(0, shadow_cnt - 1)]
                              ^ (32'd1 << $urandom_range(0, 31));
                else
                    operand = $urandom;
            end
            else if (r < enum_lim)
            begin
                op      = CMD_ENUM;
                operand = $urandom;                    // ignored by the block
            end
            else
            begin
                op      = CMD_NOP;
                operand = $urandom;
            end
            send_word(op, operand);
            if ($urandom_range(0, 99) < pause_pct)
                sender_pause($urandom_range(1, 9));
        end
    endtask

    // Fill the table to capacity, then push on a full table: adds that bounce,
    // a full-length enumerate, a remove of the value in the top slot and a refill.
    task automatic fill_table();
        while (shadow_cnt < CAPACITY)
            send_word(CMD_ADD, pick_add_value());
        repeat (3) send_word(CMD_ADD, $urandom);
        send_word(CMD_ENUM, $urandom);
        send_word(CMD_REMOVE, shadow_vals[CAPACITY - 1]);
        send_word(CMD_ADD, $urandom);
        send_word(CMD_ADD, $urandom);
    endtask

    // ------------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------------

    function automatic void check_field(string name, logic [31:0] want_v,
                                        logic [31:0] got_v);
        if (want_v !== got_v)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h",
                     $time, name, want_v, got_v);
            error_count++;
        end
    endfunction

    // A result word stands for exactly one cycle; take it at the edge that
    // ends that cycle and match it against the oldest owed word.
    always @(posedge clk)
    begin
        set_word_t want;
        if (rst_n && done)
        begin
            if (pending_words.size() == 0)
            begin
                $display("%0t: unexpected word, expected none, got status %0h value %0h",
                         $time, status, out_value);
                error_count++;
            end
            else
            begin
                want = pending_words.pop_front();
                check_field("status",     32'(want.status), 32'(status));
                check_field("out_value",  32'(want.value),  32'(out_value));
                check_field("item_count", 32'(want.cnt),    32'(item_count));
                check_field("last",       32'(want.last),   32'(last));
            end
        end
    end

    // Watchdog: no accept and no owed word for too long ends the run.
    // Stray strobes do not count, so an endless word stream still stops.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || (done && pending_words.size() != 0))
            stall_cycles <= 0;
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        set_word_t typed_word;
        clk         = 1'b0;
        rst_n       = 1'b0;
        start       = 1'b0;
        command     = CMD_ADD;
        item_value  = '0;
        shadow_cnt  = 0;
        error_count = 0;

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // Directed table. Typed rows replace the shadow's word with the one
        // written in the table; the shadow still tracks the state.
        foreach (dir_plan[k])
        begin
            send_word(dir_plan[k].op, dir_plan[k].operand);
            if (dir_plan[k].typed)
            begin
                typed_word.status = dir_plan[k].status;
                typed_word.value  = '0;
                typed_word.cnt    = dir_plan[k].cnt;
                typed_word.last   = 1'b1;
                pending_words[pending_words.size() - 1] = typed_word;
            end
            if ($urandom_range(0, 2) == 0)
                sender_pause($urandom_range(1, 9));
        end

        // hold off until the block has answered everything
        wait_drained();

        run_traffic(MODE_MIX,    40, 1'b0);
        run_traffic(MODE_GROW,   40, 1'b0);
        fill_table();
        wait_drained();
        run_traffic(MODE_SHRINK, 60, 1'b0);
        run_traffic(MODE_MIX,    30, 1'b0);
        // closing stretch with the sender never idle
        run_traffic(MODE_MIX,    40, 1'b1);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0 && pending_words.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> files.f
rtl/core/uset_pkg.sv
rtl/core/unordered_set_swap_remove.sv
test/tb_unordered_set_swap_remove.sv
